/* sv/lcw_pkg.sv */
// lcw_pkg: shared types, codes and the outcode function of the line clipper.
// Used by every module of line_clip_to_window; depends on nothing.
package lcw_pkg;

  localparam int COORD_W    = 16;
  localparam int OC_W       = 4;
  localparam int MAX_ROUNDS = 8;
  localparam int ROUND_W    = $clog2(MAX_ROUNDS + 1);

  localparam logic [OC_W-1:0] OC_TOP    = 4'd8;
  localparam logic [OC_W-1:0] OC_BOTTOM = 4'd4;
  localparam logic [OC_W-1:0] OC_RIGHT  = 4'd2;
  localparam logic [OC_W-1:0] OC_LEFT   = 4'd1;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t RST_LEFT   = -16'sd1600;
  localparam coord_t RST_BOTTOM = -16'sd1600;
  localparam coord_t RST_RIGHT  = 16'sd1600;
  localparam coord_t RST_TOP    = 16'sd1600;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_word_t;

  typedef struct packed {
    logic   accepted;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } out_word_t;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } window_t;

  typedef struct packed {
    in_word_t        seg;
    logic [OC_W-1:0] ca;
    logic [OC_W-1:0] cb;
  } job_t;

  function automatic logic [OC_W-1:0] outcode(window_t w, coord_t x, coord_t y);
    logic [OC_W-1:0] c;
    c = '0;
    if (y > w.top)    c = c | OC_TOP;
    if (y < w.bottom) c = c | OC_BOTTOM;
    if (x > w.right)  c = c | OC_RIGHT;
    if (x < w.left)   c = c | OC_LEFT;
    return c;
  endfunction

endpackage

/* sv/lcw_queue.sv */
// lcw_queue: two-entry job queue between front and back.
// Depends on lcw_pkg.
module lcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lcw_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output lcw_pkg::job_t head
);

  lcw_pkg::job_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

/* sv/lcw_front.sv */
// lcw_front: input stage; registers a segment and tags it with both outcodes.
// Depends on lcw_pkg; feeds lcw_queue.
module lcw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcw_pkg::in_word_t in_word,
  input  lcw_pkg::window_t  win,
  input  logic              q_full,
  output logic              push,
  output lcw_pkg::job_t     push_job
);

  logic              held;
  lcw_pkg::in_word_t seg;

  assign push     = held && !q_full;
  assign in_ready = !held || push;

  always_comb begin
    push_job.seg = seg;
    push_job.ca  = lcw_pkg::outcode(win, seg.start_x, seg.start_y);
    push_job.cb  = lcw_pkg::outcode(win, seg.end_x, seg.end_y);
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      seg <= in_word;
    end
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

endmodule

/* sv/lcw_back.sv */
// lcw_back: clip rounds; one multiply and a bit-serial divide per round,
// then the result register. Depends on lcw_pkg; fed by lcw_queue.
module lcw_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_avail,
  input  lcw_pkg::job_t      q_head,
  output logic               pop,
  input  lcw_pkg::window_t   win,
  output logic               out_valid,
  input  logic               out_ready,
  output lcw_pkg::out_word_t out_word
);

  localparam int W   = lcw_pkg::COORD_W;
  localparam int CNT_W = $clog2(W + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;

  logic [2:0] state;

  lcw_pkg::coord_t xa, ya, xb, yb;
  logic [lcw_pkg::OC_W-1:0] ca, cb;
  logic [lcw_pkg::ROUND_W-1:0] rnd;
  logic            first;
  logic            y_edge;
  lcw_pkg::coord_t edge_c;
  lcw_pkg::coord_t base;
  logic            neg;
  logic            den_zero;
  logic [W-1:0]    a_mag, b_mag, d_mag;
  logic [2*W-1:0]  prod;
  logic [W:0]      rem;
  logic [W-1:0]    lo;
  logic [W-1:0]    quo;
  logic [CNT_W-1:0] cnt;

  // round setup
  logic [lcw_pkg::OC_W-1:0] c;
  logic            c_y_edge;
  lcw_pkg::coord_t c_edge;
  logic signed [W:0] dx, dy, num, span, den;
  logic            slot_free;
  logic            decide;
  logic            acc;
  logic            emit;

  function automatic logic [W-1:0] mag(logic signed [W:0] v);
    logic signed [W:0] t;
    t = v[W] ? -v : v;
    return t[W-1:0];
  endfunction

  always_comb begin
    c  = (ca != '0) ? ca : cb;
    dx = {xb[W-1], xb} - {xa[W-1], xa};
    dy = {yb[W-1], yb} - {ya[W-1], ya};
    if ((c & lcw_pkg::OC_TOP) != '0) begin
      c_y_edge = 1'b1;
      c_edge   = win.top;
    end else if ((c & lcw_pkg::OC_BOTTOM) != '0) begin
      c_y_edge = 1'b1;
      c_edge   = win.bottom;
    end else if ((c & lcw_pkg::OC_RIGHT) != '0) begin
      c_y_edge = 1'b0;
      c_edge   = win.right;
    end else begin
      c_y_edge = 1'b0;
      c_edge   = win.left;
    end
    if (c_y_edge) begin
      span = dx;
      den  = dy;
      num  = {c_edge[W-1], c_edge} - {ya[W-1], ya};
    end else begin
      span = dy;
      den  = dx;
      num  = {c_edge[W-1], c_edge} - {xa[W-1], xa};
    end
  end

  assign acc       = ((ca | cb) == '0);
  assign decide    = acc || ((ca & cb) != '0) ||
                     (rnd == lcw_pkg::ROUND_W'(lcw_pkg::MAX_ROUNDS));
  assign slot_free = !out_valid || out_ready;
  assign emit      = (state == S_CHECK) && decide && slot_free;
  assign pop       = (state == S_IDLE) && q_avail;
  assign prod      = a_mag * b_mag;

  // divide step; the quotient fits W bits, so the top half starts the remainder
  logic [W:0] r2;
  logic       qbit;
  assign r2   = {rem[W-1:0], lo[W-1]};
  assign qbit = (r2 >= {1'b0, d_mag});

  // endpoint update
  logic signed [W:0] moved;
  lcw_pkg::coord_t   newc, nx, ny;
  always_comb begin
    moved = neg ? ({base[W-1], base} - {1'b0, quo}) : ({base[W-1], base} + {1'b0, quo});
    newc  = den_zero ? base : moved[W-1:0];
    nx    = y_edge ? newc : edge_c;
    ny    = y_edge ? edge_c : newc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_avail) begin
            xa    <= q_head.seg.start_x;
            ya    <= q_head.seg.start_y;
            xb    <= q_head.seg.end_x;
            yb    <= q_head.seg.end_y;
            ca    <= q_head.ca;
            cb    <= q_head.cb;
            rnd   <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (decide) begin
            if (emit) begin
              out_word.accepted     <= acc;
              out_word.clip_start_x <= acc ? xa : '0;
              out_word.clip_start_y <= acc ? ya : '0;
              out_word.clip_end_x   <= acc ? xb : '0;
              out_word.clip_end_y   <= acc ? yb : '0;
              state                 <= S_IDLE;
            end
          end else begin
            first    <= (ca != '0);
            y_edge   <= c_y_edge;
            edge_c   <= c_edge;
            base     <= c_y_edge ? xa : ya;
            neg      <= span[W] ^ num[W] ^ den[W];
            den_zero <= (den == '0);
            a_mag    <= mag(span);
            b_mag    <= mag(num);
            d_mag    <= mag(den);
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          rem   <= {1'b0, prod[2*W-1:W]};
          lo    <= prod[W-1:0];
          quo   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= qbit ? (r2 - {1'b0, d_mag}) : r2;
          lo  <= {lo[W-2:0], 1'b0};
          quo <= {quo[W-2:0], qbit};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(W - 1)) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (first) begin
            xa <= nx;
            ya <= ny;
            ca <= lcw_pkg::outcode(win, nx, ny);
          end else begin
            xb <= nx;
            yb <= ny;
            cb <= lcw_pkg::outcode(win, nx, ny);
          end
          rnd   <= rnd + 1'b1;
          state <= S_CHECK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/line_clip_to_window.sv */
// line_clip_to_window: top level; window registers, front, queue and back.
// Depends on lcw_pkg, lcw_front, lcw_queue, lcw_back.
//
// Usage:
//   in channel  (in_valid/in_ready/in_word): one segment, two endpoints.
//   out channel (out_valid/out_ready/out_word): accept flag and clipped
//   endpoints; all four coordinates are zero when the segment is rejected.
//   cfg port (cfg_we/cfg_index/cfg_data): window left, bottom, right, top;
//   write only while no segment is in flight.
// Clip rounds: a segment decided at once needs none; each clip round runs
//   setup, multiply, 16 divide steps and update; a sane window needs
//   at most 4 rounds; an inverted window stops at the 8-round limit.
// Throughput: one segment at a time in the clip engine; the 16-step
//   restoring divider sets the round time. The input register and a
//   two-entry queue keep accepting while the engine works.
// Reset: clears all handshake state and loads the window to +/-1600.
// Stall: a held result stays stable; the engine waits on the result
//   register, the queue fills, then in_ready drops.
module line_clip_to_window (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lcw_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output lcw_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  lcw_pkg::coord_t    cfg_data
);

  lcw_pkg::window_t win;
  logic             q_full, q_avail, push, pop;
  lcw_pkg::job_t    push_job, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.left   <= lcw_pkg::RST_LEFT;
      win.bottom <= lcw_pkg::RST_BOTTOM;
      win.right  <= lcw_pkg::RST_RIGHT;
      win.top    <= lcw_pkg::RST_TOP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcw_pkg::REG_LEFT:   win.left   <= cfg_data;
        lcw_pkg::REG_BOTTOM: win.bottom <= cfg_data;
        lcw_pkg::REG_RIGHT:  win.right  <= cfg_data;
        lcw_pkg::REG_TOP:    win.top    <= cfg_data;
        default: ;
      endcase
    end
  end

  lcw_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_word, .win,
    .q_full, .push, .push_job
  );

  lcw_queue u_queue (
    .clk, .rst, .push, .push_job, .full(q_full),
    .pop, .avail(q_avail), .head(q_head)
  );

  lcw_back u_back (
    .clk, .rst, .q_avail, .q_head, .pop, .win,
    .out_valid, .out_ready, .out_word
  );

endmodule

/* sv/lcw_checker.sv */
// lcw_checker: port-level checks of line_clip_to_window, bound to the top.
// Depends on lcw_pkg.
module lcw_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input lcw_pkg::out_word_t out_word,
  input logic               cfg_we,
  input logic [1:0]         cfg_index,
  input lcw_pkg::coord_t    cfg_data
);

  lcw_pkg::window_t w;

  always_ff @(posedge clk) begin
    if (rst) begin
      w.left   <= lcw_pkg::RST_LEFT;
      w.bottom <= lcw_pkg::RST_BOTTOM;
      w.right  <= lcw_pkg::RST_RIGHT;
      w.top    <= lcw_pkg::RST_TOP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcw_pkg::REG_LEFT:   w.left   <= cfg_data;
        lcw_pkg::REG_BOTTOM: w.bottom <= cfg_data;
        lcw_pkg::REG_RIGHT:  w.right  <= cfg_data;
        lcw_pkg::REG_TOP:    w.top    <= cfg_data;
        default: ;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.accepted |->
      out_word.clip_start_x == '0 && out_word.clip_start_y == '0 &&
      out_word.clip_end_x == '0 && out_word.clip_end_y == '0)
    else $error("rejected word with nonzero endpoints");

  a_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.accepted |->
      out_word.clip_start_x >= w.left && out_word.clip_start_x <= w.right &&
      out_word.clip_end_x >= w.left && out_word.clip_end_x <= w.right &&
      out_word.clip_start_y >= w.bottom && out_word.clip_start_y <= w.top &&
      out_word.clip_end_y >= w.bottom && out_word.clip_end_y <= w.top)
    else $error("accepted endpoint outside window");

endmodule

bind line_clip_to_window lcw_checker u_lcw_checker (
  .clk, .rst, .out_valid, .out_ready, .out_word, .cfg_we, .cfg_index, .cfg_data
);

/* tb/sv/line_clip_to_window_checker.sv */
// line_clip_to_window_checker: watches both channels of the line clipper,
// predicts each result from its own copy of the window and compares it.
// Depends on lcw_pkg.
module line_clip_to_window_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  lcw_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_ready,
  input  lcw_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  lcw_pkg::coord_t    cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  lcw_pkg::window_t   win;
  lcw_pkg::out_word_t clip_q[$];

  assign pending = clip_q.size();

  function automatic logic [3:0] region(lcw_pkg::window_t w, longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (y > longint'(w.top))    c |= lcw_pkg::OC_TOP;
    if (y < longint'(w.bottom)) c |= lcw_pkg::OC_BOTTOM;
    if (x > longint'(w.right))  c |= lcw_pkg::OC_RIGHT;
    if (x < longint'(w.left))   c |= lcw_pkg::OC_LEFT;
    return c;
  endfunction

  // base + trunc(span*num/den); zero divisor leaves base
  function automatic longint edge_cross(longint base, longint span, longint num,
                                        longint den);
    longint p;
    if (den == 0) return base;
    p = span * num;
    return base + p / den;
  endfunction

  function automatic lcw_pkg::out_word_t clip_segment(lcw_pkg::window_t w,
                                                      lcw_pkg::in_word_t s);
    longint xa, ya, xb, yb, nx, ny, dx, dy;
    logic [3:0] ca, cb, c;
    logic first, acc;
    lcw_pkg::out_word_t r;
    xa = s.start_x; ya = s.start_y; xb = s.end_x; yb = s.end_y;
    ca = region(w, xa, ya);
    cb = region(w, xb, yb);
    acc = 1'b0;
    for (int rnd = 0; rnd <= lcw_pkg::MAX_ROUNDS; rnd++) begin
      if ((ca | cb) == 0) begin
        acc = 1'b1;
        break;
      end
      if ((ca & cb) != 0 || rnd == lcw_pkg::MAX_ROUNDS) break;
      first = ca != 0;
      c = first ? ca : cb;
      dx = xb - xa;
      dy = yb - ya;
      if (c & lcw_pkg::OC_TOP) begin
        ny = w.top;
        nx = edge_cross(xa, dx, ny - ya, dy);
      end else if (c & lcw_pkg::OC_BOTTOM) begin
        ny = w.bottom;
        nx = edge_cross(xa, dx, ny - ya, dy);
      end else if (c & lcw_pkg::OC_RIGHT) begin
        nx = w.right;
        ny = edge_cross(ya, dy, nx - xa, dx);
      end else begin
        nx = w.left;
        ny = edge_cross(ya, dy, nx - xa, dx);
      end
      if (first) begin
        xa = nx; ya = ny; ca = region(w, xa, ya);
      end else begin
        xb = nx; yb = ny; cb = region(w, xb, yb);
      end
    end
    r = '0;
    if (acc) begin
      r.accepted = 1'b1;
      r.clip_start_x = lcw_pkg::coord_t'(xa);
      r.clip_start_y = lcw_pkg::coord_t'(ya);
      r.clip_end_x = lcw_pkg::coord_t'(xb);
      r.clip_end_y = lcw_pkg::coord_t'(yb);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    lcw_pkg::out_word_t exp_w;
    if (rst) begin
      win <= '{left: lcw_pkg::RST_LEFT, bottom: lcw_pkg::RST_BOTTOM,
               right: lcw_pkg::RST_RIGHT, top: lcw_pkg::RST_TOP};
      clip_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lcw_pkg::REG_LEFT: win.left <= cfg_data;
          lcw_pkg::REG_BOTTOM: win.bottom <= cfg_data;
          lcw_pkg::REG_RIGHT: win.right <= cfg_data;
          lcw_pkg::REG_TOP: win.top <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) clip_q.push_back(clip_segment(win, in_word));
      if (out_valid && out_ready) begin
        if (clip_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %h", out_word);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = clip_q.pop_front();
          if (exp_w !== out_word) begin
            if (fail_count < 10)
              $display("word wrong: exp acc=%0d %0d %0d %0d %0d got acc=%0d %0d %0d %0d %0d",
                exp_w.accepted, exp_w.clip_start_x, exp_w.clip_start_y,
                exp_w.clip_end_x, exp_w.clip_end_y, out_word.accepted,
                out_word.clip_start_x, out_word.clip_start_y,
                out_word.clip_end_x, out_word.clip_end_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/sv/line_clip_to_window_test.sv */
// line_clip_to_window_test: drives segments, window writes and stalls into
// the line clipper and gives the verdict. Depends on lcw_pkg, the block and
// line_clip_to_window_checker.
module line_clip_to_window_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst, in_valid, in_ready, out_valid, out_ready, cfg_we;
  lcw_pkg::in_word_t in_word;
  lcw_pkg::out_word_t out_word;
  logic [1:0] cfg_index;
  lcw_pkg::coord_t cfg_data;
  int fail_count, pending, cycles;
  int send_idle, recv_idle;

  line_clip_to_window u_dut (.*);
  line_clip_to_window_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("line_clip_to_window: mismatch");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  task automatic write_reg(logic [1:0] idx, lcw_pkg::coord_t v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic set_window(int l, int b, int r, int t);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    write_reg(lcw_pkg::REG_LEFT, lcw_pkg::coord_t'(l));
    write_reg(lcw_pkg::REG_BOTTOM, lcw_pkg::coord_t'(b));
    write_reg(lcw_pkg::REG_RIGHT, lcw_pkg::coord_t'(r));
    write_reg(lcw_pkg::REG_TOP, lcw_pkg::coord_t'(t));
    cfg_we <= 0;
  endtask

  task automatic send_segment(int sx, int sy, int ex, int ey);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_word <= '{start_x: lcw_pkg::coord_t'(sx), start_y: lcw_pkg::coord_t'(sy),
                 end_x: lcw_pkg::coord_t'(ex), end_y: lcw_pkg::coord_t'(ey)};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic int near_coord();
    case ($urandom_range(3))
      0: return int'(lcw_pkg::coord_t'($urandom));
      default: return int'($urandom_range(6000)) - 3000;
    endcase
  endfunction

  task automatic random_segments(int n);
    for (int i = 0; i < n; i++)
      send_segment(near_coord(), near_coord(), near_coord(), near_coord());
  endtask

  initial begin
    rst = 1; in_valid = 0; in_word = '0; out_ready = 0; cfg_we = 0;
    cfg_index = '0; cfg_data = '0; cycles = 0; send_idle = 14; recv_idle = 84;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_segment(0, 0, 100, 100);
    send_segment(-3000, 0, 3000, 0);
    send_segment(0, -3000, 0, 3000);
    send_segment(-3000, -3000, 3000, 3000);
    send_segment(-3000, 2000, 3000, 2500);
    send_segment(2000, -3000, 2500, 3000);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-32768, 100, 32767, -100);
    send_segment(1600, 1600, -1600, -1600);
    send_segment(1601, 0, 3000, 5);
    send_segment(-1, 2000, 5, -2000);
    send_segment(-2000, 1700, 1700, -2000);
    send_segment(-32768, -32768, -32768, -32768);
    send_segment(0, 0, 0, 0);
    set_window(-32768, -32768, 32767, 32767);
    send_segment(-32768, 32767, 32767, -32768);
    send_segment(-5, 9, 300, -700);
    random_segments(100);
    set_window(500, 400, -500, -400);
    send_segment(-3000, 0, 3000, 10);
    send_segment(0, -3000, 10, 3000);
    random_segments(60);
    set_window(0, 0, 0, 0);
    send_segment(-100, -100, 100, 100);
    random_segments(60);
    set_window(-1600, -1600, 1600, 1600);
    random_segments(250);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    send_idle = 84; recv_idle = 14;
    set_window(-200, -1000, 2500, 300);
    random_segments(250);
    send_idle = 0; recv_idle = 0;
    set_window(32767, -32768, 32767, 32767);
    random_segments(80);
    set_window(-2500, 37, -100, 2900);
    random_segments(200);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("line_clip_to_window: match");
    else $display("line_clip_to_window: mismatch");
    $finish;
  end
endmodule
